@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and helpers for the bitmap identifier pool allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_POOLS_DEF      = 16;
  localparam int MAX_POOL_WORDS_DEF = 16;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_REG   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_UNREG        = 3'd1,
    STAT_FULL         = 3'd2,
    STAT_ALREADY_FREE = 3'd3,
    STAT_RANGE        = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FREE_CHK,
    S_REG_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] pool;
    logic [8:0] slot;
    logic [4:0] pool_words;
  } in_item_t;

  typedef struct packed {
    logic [8:0] result_index;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic    load_item;
    logic    decode;
    logic    scan_step;
    logic    commit;
    logic    free_write;
    logic    clr_write;
    logic    clr_init;
    logic    res_load;
    logic    res_found;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    pool_ok;
    logic    slot_ok;
    logic    found;
    logic    scan_end;
    logic    bit_set;
    logic    clr_last;
    logic    out_free;
  } dp_stat_t;

  function automatic logic [4:0] lowest_one(input logic [31:0] v);
    logic [4:0] pos;
    pos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        pos = 5'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ rtl/bpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer of the allocator: decodes an item and steps the datapath.
// ----------------------------------------------------------------------------
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output cmd_t     cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clr_write = 1'b1;
        cmd.clr_init  = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        case (st.act)
          ACT_ALLOC: begin
            if (!st.pool_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_UNREG;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          ACT_FREE: begin
            if (!st.pool_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_UNREG;
              state_nxt      = S_DONE;
            end else if (!st.slot_ok) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_RANGE;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_FREE_CHK;
            end
          end
          ACT_REG: begin
            state_nxt = S_SCAN;
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STAT_OK;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (st.found) begin
          cmd.commit     = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_found  = 1'b1;
          cmd.res_status = STAT_OK;
          state_nxt      = (st.act == ACT_REG) ? S_REG_CLR : S_DONE;
        end else if (st.scan_end) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FREE_CHK: begin
        cmd.res_load = 1'b1;
        if (st.bit_set) begin
          cmd.free_write = 1'b1;
          cmd.res_status = STAT_OK;
        end else begin
          cmd.res_status = STAT_ALREADY_FREE;
        end
        state_nxt = S_DONE;
      end
      S_REG_CLR: begin
        cmd.clr_write = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bpa_dp.sv @@
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath: bitmap memory, pool tables, word scanner and result registers.
// ----------------------------------------------------------------------------
module bpa_dp
  import bpa_pkg::*;
#(
  parameter int NUM_POOLS      = NUM_POOLS_DEF,
  parameter int MAX_POOL_WORDS = MAX_POOL_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready,
  input  cmd_t      cmd,
  output dp_stat_t  st
);

  localparam int DEPTH = NUM_POOLS * MAX_POOL_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(NUM_POOLS);
  localparam int WW    = (MAX_POOL_WORDS > 1) ? $clog2(MAX_POOL_WORDS) : 1;
  localparam int LW    = $clog2(MAX_POOL_WORDS + 1);
  localparam int BW    = WW + 6;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_r;

  action_t           act_r;
  logic [3:0]        pool_r;
  logic [8:0]        slot_r;
  logic [4:0]        words_r;

  logic [LW-1:0]     len_r [NUM_POOLS];
  logic [NUM_POOLS-1:0] reg_r;
  logic [PW-1:0]     sp_r;
  logic [BW-1:0]     lim_r;
  logic [WW-1:0]     word_r;
  logic [PW-1:0]     clr_pool_r;
  logic [8:0]        res_idx_r;
  status_t           res_st_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              pool_inr;
  logic [PW-1:0]     pool_sel;
  logic [LW-1:0]     len_sel;
  logic [BW-1:0]     lim_alloc;
  logic [BW-1:0]     len0_bits;
  logic [BW-1:0]     lim_reg;
  logic [31:0]       zero_vec;
  logic              has_zero;
  logic [4:0]        pe;
  logic [BW-1:0]     z;
  logic [WW:0]       word_inc;
  logic              found;
  logic              scan_end;
  logic              word_last;
  logic [WW-1:0]     word_next;
  logic [WW-1:0]     slot_word;
  logic [PW-1:0]     desc;
  logic [LW-1:0]     words_sat;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [31:0]       mem_wdata;
  logic [AW-1:0]     mem_raddr;

  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p,
                                            input logic [WW-1:0] w);
    return AW'(p * MAX_POOL_WORDS) + AW'(w);
  endfunction

  always_comb begin
    pool_inr  = int'(pool_r) < NUM_POOLS;
    pool_sel  = pool_inr ? PW'(pool_r) : '0;
    len_sel   = len_r[pool_sel];
    lim_alloc = BW'({len_sel, 5'b0});
    len0_bits = BW'({len_r[0], 5'b0});
    lim_reg   = (len0_bits < BW'(NUM_POOLS)) ? len0_bits : BW'(NUM_POOLS);
    zero_vec  = ~rdata_r;
    has_zero  = |zero_vec;
    pe        = lowest_one(zero_vec);
    z         = BW'({word_r, 5'b0}) + BW'(pe);
    word_inc  = {1'b0, word_r} + (WW + 1)'(1);
    found     = has_zero && (z < lim_r);
    scan_end  = {word_inc, 5'b0} >= lim_r;
    word_last = word_r == WW'(MAX_POOL_WORDS - 1);
    word_next = word_last ? word_r : word_inc[WW-1:0];
    slot_word = WW'(slot_r[8:5]);
    desc      = z[PW-1:0];
    words_sat = (int'(words_r) > MAX_POOL_WORDS) ? LW'(MAX_POOL_WORDS) : LW'(words_r);
  end

  always_comb begin
    if (cmd.decode) begin
      if (act_r == ACT_FREE) begin
        mem_raddr = addr_of(pool_sel, slot_word);
      end else begin
        mem_raddr = addr_of((act_r == ACT_REG) ? '0 : pool_sel, '0);
      end
    end else begin
      mem_raddr = addr_of(sp_r, word_next);
    end
    mem_we = cmd.commit | cmd.free_write | cmd.clr_write;
    if (cmd.commit) begin
      mem_waddr = addr_of(sp_r, word_r);
      mem_wdata = rdata_r | (32'd1 << pe);
    end else if (cmd.free_write) begin
      mem_waddr = addr_of(pool_sel, slot_word);
      mem_wdata = rdata_r & ~(32'd1 << slot_r[4:0]);
    end else begin
      mem_waddr = addr_of(clr_pool_r, word_r);
      mem_wdata = (cmd.clr_init && (word_r == '0)) ? 32'd1 : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r   <= action_t'(in_item.action);
      pool_r  <= in_item.pool;
      slot_r  <= in_item.slot;
      words_r <= in_item.pool_words;
    end
    if (cmd.decode) begin
      sp_r  <= (act_r == ACT_REG) ? '0 : pool_sel;
      lim_r <= (act_r == ACT_REG) ? lim_reg : lim_alloc;
    end
    if (cmd.res_load) begin
      res_idx_r <= cmd.res_found ? 9'(z) : 9'd0;
      res_st_r  <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_item_r.result_index <= res_idx_r;
      out_item_r.status       <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        len_r[i] <= '0;
      end
      len_r[0]    <= LW'(MAX_POOL_WORDS);
      reg_r       <= NUM_POOLS'(1);
      word_r      <= '0;
      clr_pool_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && (act_r == ACT_REG)) begin
        reg_r[desc] <= 1'b1;
        len_r[desc] <= words_sat;
        clr_pool_r  <= desc;
      end
      if (cmd.decode || cmd.commit) begin
        word_r <= '0;
      end else if (cmd.scan_step) begin
        word_r <= word_next;
      end else if (cmd.clr_write) begin
        word_r <= word_inc[WW-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.act      = act_r;
  assign st.pool_ok  = pool_inr && reg_r[pool_sel];
  assign st.slot_ok  = 32'(slot_r) < 32'({len_sel, 5'b0});
  assign st.found    = found;
  assign st.scan_end = scan_end;
  assign st.bit_set  = rdata_r[slot_r[4:0]];
  assign st.clr_last = word_last;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_item  = out_item_r;
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.commit, cmd.free_write, cmd.clr_write}))
    else $error("more than one bitmap write source active");

  a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (!found && !scan_end))
    else $error("scan stepped past a hit or the pool limit");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote an item not yet taken");

  a_desc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (act_r == ACT_REG)) |-> (z < BW'(NUM_POOLS)))
    else $error("new pool descriptor out of range");
`endif

endmodule

@@ rtl/bitmap_id_pool_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_id_pool_allocator_top
// Identifier pools kept as bitmaps, with allocate, free and register items.
// ----------------------------------------------------------------------------
// One item is handled at a time, and a finished result waits in an output
// register so that the next item can be taken meanwhile. An allocate or a
// register item reads the bitmap memory one 32-bit word per cycle through its
// single read port, and a register item then clears the new pool. After reset the
// block initializes pool 0 before it takes the first item.
module bitmap_id_pool_allocator_top
  import bpa_pkg::*;
#(
  parameter int NUM_POOLS      = NUM_POOLS_DEF,
  parameter int MAX_POOL_WORDS = MAX_POOL_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  cmd_t     cmd;
  dp_stat_t st;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bpa_dp #(
    .NUM_POOLS      (NUM_POOLS),
    .MAX_POOL_WORDS (MAX_POOL_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
